// ===== sv/fuxc_pkg.sv =====
package fuxc_pkg;

  // framing bytes
  localparam logic [7:0] FLAG_BYTE    = 8'h7e;
  localparam logic [7:0] ESC_BYTE     = 8'h7d;
  localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
  localparam logic [7:0] ESC_FOR_ESC  = 8'h01;

  // result kinds
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // frame-end status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_MISMATCH   = 2'd1;
  localparam logic [1:0] ST_BAD_ESCAPE = 2'd2;
  localparam logic [1:0] ST_TOO_SHORT  = 2'd3;

  // saturation point of the unescaped byte count
  localparam logic [1:0] COUNT_MAX = 2'd2;

  typedef struct packed {
    logic       in_frame;
    logic       escape_pending;
    logic [7:0] held_byte;
    logic       held_valid;
    logic [7:0] running_xor;
    logic [1:0] byte_count;
    logic       bad_escape_seen;
  } frame_state_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] frame_status;
  } result_t;

endpackage

// ===== sv/fuxc_core.sv =====
module fuxc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  output fuxc_pkg::result_t  res
);

  fuxc_pkg::frame_state_t st_r, st_nxt;

  logic       do_accept;
  logic [7:0] accept_val;
  logic       bad;

  always_comb begin
    st_nxt       = st_r;
    res          = '0;
    do_accept    = 1'b0;
    accept_val   = rx_byte;
    bad          = st_r.bad_escape_seen | st_r.escape_pending;

    if (!st_r.in_frame) begin
      // hunting for the opening flag
      if (rx_byte == fuxc_pkg::FLAG_BYTE) begin
        st_nxt          = '0;
        st_nxt.in_frame = 1'b1;
      end
    end else if (rx_byte == fuxc_pkg::FLAG_BYTE) begin
      // closing flag, also opens the next frame
      res.valid = bad | (st_r.byte_count != 2'd0);
      res.kind  = fuxc_pkg::KIND_FRAME_END;
      if (bad) begin
        res.frame_status = fuxc_pkg::ST_BAD_ESCAPE;
      end else if (st_r.byte_count < fuxc_pkg::COUNT_MAX) begin
        res.frame_status = fuxc_pkg::ST_TOO_SHORT;
      end else if (st_r.held_byte != st_r.running_xor) begin
        res.frame_status = fuxc_pkg::ST_MISMATCH;
      end else begin
        res.frame_status = fuxc_pkg::ST_OK;
      end
      st_nxt          = '0;
      st_nxt.in_frame = 1'b1;
    end else if (st_r.escape_pending) begin
      st_nxt.escape_pending = 1'b0;
      if (rx_byte == fuxc_pkg::ESC_FOR_FLAG) begin
        do_accept  = 1'b1;
        accept_val = fuxc_pkg::FLAG_BYTE;
      end else if (rx_byte == fuxc_pkg::ESC_FOR_ESC) begin
        do_accept  = 1'b1;
        accept_val = fuxc_pkg::ESC_BYTE;
      end else begin
        st_nxt.bad_escape_seen = 1'b1;
      end
    end else if (rx_byte == fuxc_pkg::ESC_BYTE) begin
      st_nxt.escape_pending = 1'b1;
    end else begin
      do_accept = 1'b1;
    end

    // held-back byte goes out when the next unescaped byte arrives
    if (do_accept) begin
      if (st_r.held_valid) begin
        res.valid          = 1'b1;
        res.kind           = fuxc_pkg::KIND_PAYLOAD;
        res.data_byte      = st_r.held_byte;
        st_nxt.running_xor = st_r.running_xor ^ st_r.held_byte;
      end
      st_nxt.held_byte  = accept_val;
      st_nxt.held_valid = 1'b1;
      if (st_r.byte_count < fuxc_pkg::COUNT_MAX) begin
        st_nxt.byte_count = st_r.byte_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== sv/frame_unescape_xor_check.sv =====
// path: a byte is held in the input register, goes through the frame logic, and
// its result is registered in the result register, where the receiver takes it
// throughput: one byte per cycle, sustained while the result side keeps taking
// results; set by the single pass through the unescape and checksum logic
// reset: synchronous active-low rst_n clears the frame state (hunting for the
// first flag) and the valid flags of the input register and the result register
module frame_unescape_xor_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_frame_status
);

  // input register stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // result register
  logic       out_valid_r;
  logic       out_kind_r;
  logic [7:0] out_data_r;
  logic [1:0] out_status_r;

  fuxc_pkg::result_t res;

  logic out_free;
  logic advance;

  // result slot can take a new entry when empty or being emptied this cycle
  assign out_free = !out_valid_r || out_ready;
  // the registered byte goes through the frame logic when the slot is free
  assign advance  = s1_valid_r && out_free;
  // take a fresh byte while the previous one moves on, even with a result waiting
  assign in_ready = !s1_valid_r || out_free;

  fuxc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid && out_free) begin
      out_kind_r   <= res.kind;
      out_data_r   <= res.data_byte;
      out_status_r <= res.frame_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_data_byte    = out_data_r;
  assign out_frame_status = out_status_r;

  // a frame-end result never carries a data byte
  a_end_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == fuxc_pkg::KIND_FRAME_END) |-> out_data_byte == 8'd0)
    else $error("frame-end result with non-zero data byte");

  // a payload result never carries a status
  a_payload_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == fuxc_pkg::KIND_PAYLOAD) |-> out_frame_status == fuxc_pkg::ST_OK)
    else $error("payload result with non-zero status");

  // input side stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && s1_valid_r))
    else $error("input stalled without a blocked result");

  // nothing is offered straight after reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== tb/frame_unescape_xor_check_tb.sv =====
module frame_unescape_xor_check_tb;

  // one expected result: kind, payload byte, frame-end status
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [1:0] status;
  } frame_result_t;

  // one raw byte waiting to be sent; wait_drain holds it back until every
  // expected result has arrived
  typedef struct packed {
    logic [7:0] raw;
    logic       wait_drain;
  } tx_byte_t;

  localparam int CLK_PERIOD = 20;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int RANDOM_BYTES = 1000;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_REPORTS = 10;

  // directed opening: junk while hunting, back-to-back flags, a good frame,
  // both escapes, a too-short frame, a checksum mismatch, a bad escape byte
  // and a flag straight after an escape
  localparam int N_DIRECTED = 27;
  localparam logic [7:0] DIRECTED [N_DIRECTED] = '{
    8'h00, 8'hff, fuxc_pkg::ESC_BYTE, fuxc_pkg::FLAG_BYTE, fuxc_pkg::FLAG_BYTE,
    8'ha5, 8'h5a, 8'hff, fuxc_pkg::FLAG_BYTE,
    fuxc_pkg::ESC_BYTE, fuxc_pkg::ESC_FOR_FLAG, fuxc_pkg::ESC_BYTE, fuxc_pkg::ESC_FOR_ESC,
    8'h03, fuxc_pkg::FLAG_BYTE,
    8'h00, fuxc_pkg::FLAG_BYTE,
    8'h01, 8'h02, 8'h00, fuxc_pkg::FLAG_BYTE,
    fuxc_pkg::ESC_BYTE, 8'h55, 8'h10, fuxc_pkg::FLAG_BYTE,
    fuxc_pkg::ESC_BYTE, fuxc_pkg::FLAG_BYTE
  };

  // bytes that hit the framing logic, mixed into random payload
  localparam logic [7:0] HOT_BYTES [6] = '{
    fuxc_pkg::FLAG_BYTE, fuxc_pkg::ESC_BYTE, fuxc_pkg::ESC_FOR_FLAG, fuxc_pkg::ESC_FOR_ESC,
    8'h00, 8'hff
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kind;
  logic [7:0] out_data_byte;
  logic [1:0] out_frame_status;

  frame_unescape_xor_check dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_status (out_frame_status)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("frame_unescape_xor_check_tb: FAIL");
    $finish;
  end

  tx_byte_t      tx_queue[$];
  frame_result_t pending_results[$];
  logic          drain_next = 1'b0;
  int            fail_count = 0;
  int            bytes_taken = 0;
  int            results_seen = 0;

  // ---------------------------------------------------------------------
  // predictor state: a private copy of the frame state
  // ---------------------------------------------------------------------
  logic       pr_in_frame = 1'b0;
  logic       pr_esc = 1'b0;
  logic [7:0] pr_held = 8'h00;
  logic       pr_held_ok = 1'b0;
  logic [7:0] pr_xor = 8'h00;
  logic [1:0] pr_count = 2'd0;
  logic       pr_bad = 1'b0;

  task automatic clear_frame_state();
    pr_esc = 1'b0;
    pr_held = 8'h00;
    pr_held_ok = 1'b0;
    pr_xor = 8'h00;
    pr_count = 2'd0;
    pr_bad = 1'b0;
  endtask

  // an unescaped byte pushes out the byte held back before it, so the last
  // byte of a frame (the checksum) is never emitted
  task automatic take_unescaped(input logic [7:0] v);
    if (pr_held_ok) begin
      pending_results.push_back({fuxc_pkg::KIND_PAYLOAD, pr_held, fuxc_pkg::ST_OK});
      pr_xor = pr_xor ^ pr_held;
    end
    pr_held = v;
    pr_held_ok = 1'b1;
    if (pr_count < fuxc_pkg::COUNT_MAX) pr_count = pr_count + 2'd1;
  endtask

  task automatic unescape_predict(input logic [7:0] b);
    logic       bad;
    logic [1:0] st;
    if (!pr_in_frame) begin
      // hunting: only a flag matters
      if (b == fuxc_pkg::FLAG_BYTE) begin
        pr_in_frame = 1'b1;
        clear_frame_state();
      end
    end else if (b == fuxc_pkg::FLAG_BYTE) begin
      // closing flag, which also opens the next frame
      bad = pr_bad || pr_esc;
      if (bad) st = fuxc_pkg::ST_BAD_ESCAPE;
      else if (pr_count < fuxc_pkg::COUNT_MAX) st = fuxc_pkg::ST_TOO_SHORT;
      else if (pr_held != pr_xor) st = fuxc_pkg::ST_MISMATCH;
      else st = fuxc_pkg::ST_OK;
      if (bad || pr_count != 2'd0)
        pending_results.push_back({fuxc_pkg::KIND_FRAME_END, 8'h00, st});
      clear_frame_state();
    end else if (pr_esc) begin
      pr_esc = 1'b0;
      if (b == fuxc_pkg::ESC_FOR_FLAG) take_unescaped(fuxc_pkg::FLAG_BYTE);
      else if (b == fuxc_pkg::ESC_FOR_ESC) take_unescaped(fuxc_pkg::ESC_BYTE);
      else pr_bad = 1'b1;
    end else if (b == fuxc_pkg::ESC_BYTE) begin
      pr_esc = 1'b1;
    end else begin
      take_unescaped(b);
    end
  endtask

  task automatic note_error(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // idle cycles before the next transaction; every third stretch of 64
  // transactions runs with no idling at all
  function automatic int idle_draw(input int seq);
    if ((seq / 64) % 3 == 0) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      4, 5, 6: return $urandom_range(1, 3);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) return HOT_BYTES[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_raw(input logic [7:0] b);
    tx_queue.push_back({b, drain_next});
    drain_next = 1'b0;
  endtask

  task automatic queue_escaped(input logic [7:0] b);
    if (b == fuxc_pkg::FLAG_BYTE) begin
      queue_raw(fuxc_pkg::ESC_BYTE);
      queue_raw(fuxc_pkg::ESC_FOR_FLAG);
    end else if (b == fuxc_pkg::ESC_BYTE) begin
      queue_raw(fuxc_pkg::ESC_BYTE);
      queue_raw(fuxc_pkg::ESC_FOR_ESC);
    end else begin
      queue_raw(b);
    end
  endtask

  // ---------------------------------------------------------------------
  // driver: predicts on every accepted transaction, then offers the next
  // byte once its idle gap has run out
  // ---------------------------------------------------------------------
  int       tx_gap;
  tx_byte_t tx_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'h00;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        unescape_predict(in_rx_byte);
        bytes_taken <= bytes_taken + 1;
      end
      // a byte still on offer keeps valid and payload untouched
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (tx_queue.size() != 0 &&
                     !(tx_queue[0].wait_drain && pending_results.size() != 0)) begin
          tx_item = tx_queue.pop_front();
          in_valid <= 1'b1;
          in_rx_byte <= tx_item.raw;
          tx_gap = idle_draw(bytes_taken);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // long receiver hold-off, once, while the sender keeps offering bytes so
  // that the block backs up and stalls its input
  // ---------------------------------------------------------------------
  logic rx_hold;
  int   hold_left;
  logic hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
      rx_hold <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) rx_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // monitor: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------
  int            rx_wait;
  frame_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          note_error($sformatf("unexpected result kind %0d data %02h status %0d",
                               out_kind, out_data_byte, out_frame_status));
        end else begin
          want = pending_results.pop_front();
          if (out_kind !== want.kind || out_data_byte !== want.data ||
              out_frame_status !== want.status)
            note_error($sformatf(
              {"result %0d: expected kind %0d data %02h status %0d, ",
               "got kind %0d data %02h status %0d"},
              results_seen, want.kind, want.data, want.status,
              out_kind, out_data_byte, out_frame_status));
        end
        rx_wait = idle_draw(results_seen);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0) && !rx_hold;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int         len;
    int         bad_at;
    int         settle;
    logic [7:0] sum;
    logic [7:0] v;
    logic       mid_drain_done;

    mid_drain_done = 1'b0;
    for (int i = 0; i < N_DIRECTED; i++) queue_raw(DIRECTED[i]);

    // the first random frame waits for the directed results to drain
    drain_next = 1'b1;
    while (tx_queue.size() < N_DIRECTED + RANDOM_BYTES) begin
      if (!mid_drain_done && tx_queue.size() >= 600) begin
        drain_next = 1'b1;
        mid_drain_done = 1'b1;
      end
      case ($urandom_range(0, 19))
        0: begin
          // empty frame: just the next flag
        end
        1: queue_escaped(pick_byte());
        2: begin
          // bad escape somewhere in the frame
          len = $urandom_range(0, 5);
          bad_at = $urandom_range(0, len);
          for (int i = 0; i <= len; i++) begin
            if (i == bad_at) begin
              queue_raw(fuxc_pkg::ESC_BYTE);
              do v = 8'($urandom_range(0, 255));
              while (v == fuxc_pkg::ESC_FOR_FLAG || v == fuxc_pkg::ESC_FOR_ESC ||
                     v == fuxc_pkg::FLAG_BYTE);
              queue_raw(v);
            end
            if (i < len) queue_escaped(pick_byte());
          end
        end
        3: begin
          // escape left dangling before the flag
          len = $urandom_range(0, 4);
          for (int i = 0; i < len; i++) queue_escaped(pick_byte());
          queue_raw(fuxc_pkg::ESC_BYTE);
        end
        4: begin
          // raw noise, unescaped
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) queue_raw(8'($urandom_range(0, 255)));
        end
        default: begin
          // well-formed frame, now and then with a wrong checksum
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
          sum = 8'h00;
          for (int i = 0; i < len; i++) begin
            v = pick_byte();
            queue_escaped(v);
            sum = sum ^ v;
          end
          if ($urandom_range(0, 6) == 0) begin
            v = 8'($urandom_range(1, 255));
            sum = sum ^ v;
          end
          queue_escaped(sum);
        end
      endcase
      queue_raw(fuxc_pkg::FLAG_BYTE);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // every byte offered and taken
    while (tx_queue.size() != 0 || in_valid) @(posedge clk);

    settle = 0;
    while (pending_results.size() != 0 && settle < 4000) begin
      @(posedge clk);
      settle++;
    end
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));

    // room for any stray result behind the input and result registers
    repeat (24) @(posedge clk);

    if (fail_count == 0) begin
      $display("frame_unescape_xor_check_tb: PASS");
    end else begin
      $display("frame_unescape_xor_check_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/fuxc_pkg.sv
sv/fuxc_core.sv
sv/frame_unescape_xor_check.sv
tb/frame_unescape_xor_check_tb.sv
